/* src/pcst_pkg.sv */
package pcst_pkg;

   // Window and access limits
   localparam int ADDR_BITS   = 16;
   localparam int MAX_ACCESS  = 64;
   localparam int PROBE_BACK  = 7;
   localparam int NEST_LIMIT  = 32;

   // Field widths on the ports
   localparam int ID_W        = 16;
   localparam int FIELD_ADDR_W = 16;
   localparam int LEN_W       = 7;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 56;

   // Internal widths
   localparam int REM_W       = 8;
   localparam int D_W         = $clog2(PROBE_BACK + 2);
   localparam int DEPTH_W     = $clog2(NEST_LIMIT + 1);
   localparam int STACK_DEPTH = 2 * NEST_LIMIT;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int TABLE_DEPTH = 2 ** ADDR_BITS;

   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
      logic [ID_W-1:0]  prod;
   } rec_type;

   // Deferred table store of an open fix-up level
   typedef struct packed {
      addr_type addr;
      rec_type  rec;
   } frame_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_W_START,
      OP_W_FRESH,
      OP_W_KEEP,
      OP_W_GROW,
      OP_W_SHRINK,
      OP_RD_CUR,
      OP_RD_BACK,
      OP_D_SUB,
      OP_D_DEC,
      OP_D_INC,
      OP_D_ONE,
      OP_TB_TRIM,
      OP_TB_TAIL,
      OP_CS_CLEAR,
      OP_CS_SKIP,
      OP_CS_SPLIT,
      OP_POP,
      OP_RESTORE,
      OP_EMIT_FULL,
      OP_EMIT_REC,
      OP_EMIT_PART,
      OP_EMIT_UNK
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_W_START,
      ST_W_CHK,
      ST_TB_RD,
      ST_TB_EV,
      ST_CS_RD,
      ST_CS_EV,
      ST_UNWIND,
      ST_RESTORE,
      ST_R_RD,
      ST_R_EV,
      ST_PB_RD,
      ST_PB_EV,
      ST_R_UNK
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic present;
      logic rec_valid;
      logic size_zero;
      logic depth_full;
      logic old_eq;
      logic old_lt;
      logic tb_eq;
      logic tb_lt;
      logic tb_tail;
      logic rem_le0;
      logic cs_split;
      logic rd_fits;
      logic pb_all;
      logic pb_part;
      logic rem_one;
      logic d_zero;
      logic d_over;
      logic sp_zero;
      logic out_free;
      logic clr_last;
   } status_type;

endpackage

/* src/producer_consumer_shadow_tracker.sv */
// Producer/consumer shadow tracker.
// Input channel req_*: one item per access. tuser carries the kind (0 read by
// a consumer, 1 write by a producer); tdata carries function ID, byte address
// and byte count. A write updates the shadow table and yields no item; a read
// yields a run of bindings on rsp_*, tlast set on the final one.
// The table holds one record per byte address of the window. Each table probe
// issues the address, then evaluates the registered read data. A read is
// accepted, then visits the records at the cursor; a byte with no record at the
// cursor is probed back (up to 7 times) before it is bound.
// A write is accepted, then enters its fix-up levels, probes entries while
// trimming or clearing, replays the deferred stores from the fix-up stack at
// the end, and finishes. One item is in work at a time; the table's single
// read port sets the pace. After reset the table is cleared one entry a cycle,
// all 65536 entries, with req_tready low. When the receiver stalls, the output
// register holds the binding and the walk waits for it; the next item is still
// taken once the current one has produced its last binding.
module producer_consumer_shadow_tracker
   import pcst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] func_id, [31:16] address, [38:32] length, [39] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] producer, [31:16] consumer, [47:32] bind_address,
   // [54:48] bind_length, [55] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   // Sequence the write fix-ups and the read walk
   pcst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   // Hold the table, fix-up stack, walk registers and output register
   pcst_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/pcst_ram.sv */
module pcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pcst_dp.sv */
module pcst_dp
   import pcst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   // Shadow table and fix-up stack ports
   rec_type                tbl_rd;
   rec_type                tbl_wdata;
   addr_type               tbl_waddr;
   addr_type               tbl_raddr;
   logic                   tbl_we;
   logic                   tbl_re;
   frame_type              stk_rd;
   frame_type              stk_wdata;
   logic                   stk_we;
   logic                   stk_re;
   logic [STACK_AW-1:0]    stk_raddr;

   // Registers
   addr_type               clr_ff, clr_in;
   logic [ID_W-1:0]        cons_ff, cons_in;
   logic [ID_W-1:0]        w_func_ff, w_func_in;
   addr_type               w_add_ff, w_add_in;
   logic [LEN_W-1:0]       w_size_ff, w_size_in;
   addr_type               cur_ff, cur_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [D_W-1:0]         d_ff, d_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;
   logic [SP_W-1:0]        sp_ff, sp_in;
   logic                   out_valid_ff, out_valid_in;
   logic [ID_W-1:0]        out_prod_ff, out_prod_in;
   logic [ID_W-1:0]        out_cons_ff, out_cons_in;
   addr_type               out_addr_ff, out_addr_in;
   logic [LEN_W-1:0]       out_len_ff, out_len_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_load;

   // Input fields
   logic [ID_W-1:0]        in_func;
   addr_type               in_addr;
   logic [LEN_W-1:0]       in_len;
   logic [LEN_W-1:0]       in_len_sat;

   // Derived values
   addr_type               back_addr;
   logic [REM_W-1:0]       len8;
   logic [REM_W-1:0]       d8;
   logic [REM_W-1:0]       size8;
   logic [REM_W-1:0]       part8;
   rec_type                own_rec;

   assign in_func    = req_tdata[ID_W-1:0];
   assign in_addr    = ADDR_BITS'(req_tdata[ID_W+FIELD_ADDR_W-1:ID_W]);
   assign in_len     = req_tdata[ID_W+FIELD_ADDR_W+LEN_W-1:ID_W+FIELD_ADDR_W];
   assign in_len_sat = (in_len > LEN_W'(MAX_ACCESS)) ? LEN_W'(MAX_ACCESS) : in_len;

   assign back_addr  = cur_ff - ADDR_BITS'(d_ff);
   assign len8       = REM_W'(tbl_rd.len);
   assign d8         = REM_W'(d_ff);
   assign size8      = REM_W'(w_size_ff);
   assign part8      = len8 - d8;
   assign own_rec    = '{valid: 1'b1, len: w_size_ff, prod: w_func_ff};

   pcst_ram #(
      .WIDTH ($bits(rec_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rd)
   );

   pcst_ram #(
      .WIDTH ($bits(frame_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff[STACK_AW-1:0]),
      .wr_data (stk_wdata),
      .rd_en   (stk_re),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

   // Status toward the controller
   always_comb begin
      status.present    = tbl_rd.valid && (tbl_rd.len != '0);
      status.rec_valid  = tbl_rd.valid;
      status.size_zero  = (w_size_ff == '0);
      status.depth_full = (depth_ff >= DEPTH_W'(NEST_LIMIT));
      status.old_eq     = (tbl_rd.len == w_size_ff);
      status.old_lt     = (tbl_rd.len < w_size_ff);
      status.tb_eq      = (len8 == d8);
      status.tb_lt      = (len8 < d8);
      status.tb_tail    = (len8 > (d8 + size8));
      status.rem_le0    = rem_ff[REM_W-1] || (rem_ff == '0);
      status.cs_split   = (rem_ff < len8);
      status.rd_fits    = (rem_ff <= len8);
      status.pb_all     = (len8 >= (d8 + rem_ff));
      status.pb_part    = (len8 > d8);
      status.rem_one    = (rem_ff == REM_W'(1));
      status.d_zero     = (d_ff == '0);
      status.d_over     = (d_ff > D_W'(PROBE_BACK));
      status.sp_zero    = (sp_ff == '0);
      status.out_free   = !out_valid_ff || rsp_tready;
      status.clr_last   = (clr_ff == '1);
   end

   // Operations
   always_comb begin
      clr_in      = clr_ff;
      cons_in     = cons_ff;
      w_func_in   = w_func_ff;
      w_add_in    = w_add_ff;
      w_size_in   = w_size_ff;
      cur_in      = cur_ff;
      rem_in      = rem_ff;
      d_in        = d_ff;
      depth_in    = depth_ff;
      sp_in       = sp_ff;
      tbl_we      = 1'b0;
      tbl_waddr   = cur_ff;
      tbl_wdata   = '0;
      tbl_re      = 1'b0;
      tbl_raddr   = cur_ff;
      stk_we      = 1'b0;
      stk_wdata   = '{addr: w_add_ff, rec: own_rec};
      stk_re      = 1'b0;
      stk_raddr   = STACK_AW'(sp_ff - SP_W'(1));
      out_load    = 1'b0;
      out_prod_in = tbl_rd.prod;
      out_cons_in = cons_ff;
      out_addr_in = cur_ff;
      out_len_in  = tbl_rd.len;
      out_last_in = 1'b0;
      case (cmd.op)
         OP_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_BITS'(1);
         end
         OP_ACCEPT: begin
            cons_in   = in_func;
            w_func_in = in_func;
            w_add_in  = in_addr;
            w_size_in = in_len_sat;
            cur_in    = in_addr;
            rem_in    = REM_W'(in_len_sat);
            depth_in  = '0;
            sp_in     = '0;
         end
         OP_W_START: begin
            depth_in  = depth_ff + DEPTH_W'(1);
            tbl_re    = 1'b1;
            tbl_raddr = w_add_ff;
         end
         OP_W_FRESH: begin
            tbl_we    = 1'b1;
            tbl_waddr = w_add_ff;
            tbl_wdata = own_rec;
            cur_in    = w_add_ff;
            d_in      = D_W'(PROBE_BACK);
         end
         OP_W_KEEP: begin
            stk_we = 1'b1;
            sp_in  = sp_ff + SP_W'(1);
         end
         OP_W_GROW: begin
            stk_we = 1'b1;
            sp_in  = sp_ff + SP_W'(1);
            cur_in = w_add_ff + ADDR_BITS'(tbl_rd.len);
            rem_in = size8 - len8;
         end
         OP_W_SHRINK: begin
            stk_we    = 1'b1;
            sp_in     = sp_ff + SP_W'(1);
            w_func_in = tbl_rd.prod;
            w_add_in  = w_add_ff + ADDR_BITS'(w_size_ff);
            w_size_in = tbl_rd.len - w_size_ff;
         end
         OP_RD_CUR: begin
            tbl_re = 1'b1;
         end
         OP_RD_BACK: begin
            tbl_re    = 1'b1;
            tbl_raddr = back_addr;
         end
         OP_D_SUB: d_in = d_ff - D_W'(tbl_rd.len);
         OP_D_DEC: d_in = d_ff - D_W'(1);
         OP_D_INC: d_in = d_ff + D_W'(1);
         OP_D_ONE: d_in = D_W'(1);
         OP_TB_TRIM: begin
            tbl_we    = 1'b1;
            tbl_waddr = back_addr;
            tbl_wdata = '{valid: 1'b1, len: LEN_W'(d_ff), prod: tbl_rd.prod};
         end
         OP_TB_TAIL: begin
            tbl_we    = 1'b1;
            tbl_waddr = back_addr;
            tbl_wdata = '{valid: 1'b1, len: LEN_W'(d_ff), prod: tbl_rd.prod};
            w_func_in = tbl_rd.prod;
            w_add_in  = w_add_ff + ADDR_BITS'(w_size_ff);
            w_size_in = LEN_W'(part8 - size8);
         end
         OP_CS_CLEAR: begin
            tbl_we = 1'b1;
            cur_in = cur_ff + ADDR_BITS'(tbl_rd.len);
            rem_in = rem_ff - len8;
         end
         OP_CS_SKIP: begin
            cur_in = cur_ff + ADDR_BITS'(1);
            rem_in = rem_ff - REM_W'(1);
         end
         OP_CS_SPLIT: begin
            stk_we    = 1'b1;
            stk_wdata = '{addr: cur_ff, rec: '0};
            sp_in     = sp_ff + SP_W'(1);
            w_func_in = tbl_rd.prod;
            w_add_in  = cur_ff + ADDR_BITS'(rem_ff);
            w_size_in = LEN_W'(len8 - rem_ff);
         end
         OP_POP: begin
            stk_re = 1'b1;
            sp_in  = sp_ff - SP_W'(1);
         end
         OP_RESTORE: begin
            tbl_we    = 1'b1;
            tbl_waddr = stk_rd.addr;
            tbl_wdata = stk_rd.rec;
         end
         OP_EMIT_FULL: begin
            out_load    = 1'b1;
            out_len_in  = LEN_W'(rem_ff);
            out_last_in = 1'b1;
         end
         OP_EMIT_REC: begin
            out_load = 1'b1;
            cur_in   = cur_ff + ADDR_BITS'(tbl_rd.len);
            rem_in   = rem_ff - len8;
         end
         OP_EMIT_PART: begin
            out_load   = 1'b1;
            out_len_in = LEN_W'(part8);
            cur_in     = cur_ff + ADDR_BITS'(part8);
            rem_in     = rem_ff - part8;
         end
         OP_EMIT_UNK: begin
            out_load    = 1'b1;
            out_prod_in = '0;
            out_len_in  = LEN_W'(1);
            out_last_in = (rem_ff == REM_W'(1));
            cur_in      = cur_ff + ADDR_BITS'(1);
            rem_in      = rem_ff - REM_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         depth_ff     <= '0;
         sp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         sp_ff        <= sp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cons_ff   <= cons_in;
      w_func_ff <= w_func_in;
      w_add_ff  <= w_add_in;
      w_size_ff <= w_size_in;
      cur_ff    <= cur_in;
      rem_ff    <= rem_in;
      d_ff      <= d_in;
      if (out_load) begin
         out_prod_ff <= out_prod_in;
         out_cons_ff <= out_cons_in;
         out_addr_ff <= out_addr_in;
         out_len_ff  <= out_len_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_len_ff, FIELD_ADDR_W'(out_addr_ff), out_cons_ff, out_prod_ff};

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("fix-up stack overflow");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(NEST_LIMIT))
      else $error("fix-up nesting past limit");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!out_valid_ff || rsp_tready))
      else $error("binding overwrites an untaken item");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_POP) |-> (sp_ff != '0))
      else $error("pop from empty fix-up stack");

endmodule

/* src/pcst_ctrl.sv */
module pcst_ctrl
   import pcst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_mode,
   input  status_type status,
   output logic       req_tready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = req_mode ? ST_W_START : ST_R_RD;
         end
         ST_W_START: begin
            state_in = (status.size_zero || status.depth_full) ? ST_UNWIND : ST_W_CHK;
         end
         ST_W_CHK: begin
            if (!status.rec_valid) state_in = ST_TB_RD;
            else if (status.old_eq) state_in = ST_UNWIND;
            else if (status.old_lt) state_in = ST_CS_RD;
            else state_in = ST_W_START;
         end
         ST_TB_RD: begin
            state_in = status.d_zero ? ST_UNWIND : ST_TB_EV;
         end
         ST_TB_EV: begin
            if (!status.present) state_in = ST_TB_RD;
            else if (status.tb_eq) state_in = ST_UNWIND;
            else if (status.tb_lt) state_in = ST_TB_RD;
            else if (status.tb_tail) state_in = ST_W_START;
            else state_in = ST_UNWIND;
         end
         ST_CS_RD: begin
            state_in = status.rem_le0 ? ST_UNWIND : ST_CS_EV;
         end
         ST_CS_EV: begin
            if (status.present && status.cs_split) state_in = ST_W_START;
            else state_in = ST_CS_RD;
         end
         ST_UNWIND: begin
            state_in = status.sp_zero ? ST_IDLE : ST_RESTORE;
         end
         ST_RESTORE: state_in = ST_UNWIND;
         ST_R_RD: begin
            state_in = status.rem_le0 ? ST_IDLE : ST_R_EV;
         end
         ST_R_EV: begin
            if (!status.present) state_in = ST_PB_RD;
            else if (status.out_free) state_in = status.rd_fits ? ST_IDLE : ST_R_RD;
         end
         ST_PB_RD: begin
            state_in = status.d_over ? ST_R_UNK : ST_PB_EV;
         end
         ST_PB_EV: begin
            if (!status.present) state_in = ST_PB_RD;
            else if (status.pb_all) begin
               if (status.out_free) state_in = ST_IDLE;
            end else if (status.pb_part) begin
               if (status.out_free) state_in = ST_R_UNK;
            end else state_in = ST_R_UNK;
         end
         ST_R_UNK: begin
            if (status.out_free) state_in = status.rem_one ? ST_IDLE : ST_R_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.op = OP_CLEAR;
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_ACCEPT;
         end
         ST_W_START: begin
            if (!status.size_zero && !status.depth_full) cmd.op = OP_W_START;
         end
         ST_W_CHK: begin
            if (!status.rec_valid) cmd.op = OP_W_FRESH;
            else if (status.old_eq) cmd.op = OP_W_KEEP;
            else if (status.old_lt) cmd.op = OP_W_GROW;
            else cmd.op = OP_W_SHRINK;
         end
         ST_TB_RD: begin
            if (!status.d_zero) cmd.op = OP_RD_BACK;
         end
         ST_TB_EV: begin
            if (!status.present) cmd.op = OP_D_DEC;
            else if (status.tb_eq) cmd.op = OP_NONE;
            else if (status.tb_lt) cmd.op = OP_D_SUB;
            else if (status.tb_tail) cmd.op = OP_TB_TAIL;
            else cmd.op = OP_TB_TRIM;
         end
         ST_CS_RD: begin
            if (!status.rem_le0) cmd.op = OP_RD_CUR;
         end
         ST_CS_EV: begin
            if (!status.present) cmd.op = OP_CS_SKIP;
            else if (status.cs_split) cmd.op = OP_CS_SPLIT;
            else cmd.op = OP_CS_CLEAR;
         end
         ST_UNWIND: begin
            if (!status.sp_zero) cmd.op = OP_POP;
         end
         ST_RESTORE: cmd.op = OP_RESTORE;
         ST_R_RD: begin
            if (!status.rem_le0) cmd.op = OP_RD_CUR;
         end
         ST_R_EV: begin
            if (!status.present) cmd.op = OP_D_ONE;
            else if (status.out_free) cmd.op = status.rd_fits ? OP_EMIT_FULL : OP_EMIT_REC;
         end
         ST_PB_RD: begin
            if (!status.d_over) cmd.op = OP_RD_BACK;
         end
         ST_PB_EV: begin
            if (!status.present) cmd.op = OP_D_INC;
            else if (status.pb_all) begin
               if (status.out_free) cmd.op = OP_EMIT_FULL;
            end else if (status.pb_part) begin
               if (status.out_free) cmd.op = OP_EMIT_PART;
            end
         end
         ST_R_UNK: begin
            if (status.out_free) cmd.op = OP_EMIT_UNK;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
